[hw/rtl/dof_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_pkg
// Shared types, constants and codon helper functions of the ORF finder.
// ----------------------------------------------------------------------------
package dof_pkg;

    localparam int POS_BITS       = 32;
    localparam int OUT_BITS       = 32;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int NUM_FRAMES     = 3;
    localparam int CODON_LEN      = 3;
    localparam int MINUS_END_GAP  = 4;

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_MINUS_STRAND    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEQUENCE_LENGTH = CFG_INDEX_BITS'(1);

    localparam logic [2:0] CODE_A = 3'd0;
    localparam logic [2:0] CODE_C = 3'd1;
    localparam logic [2:0] CODE_G = 3'd2;
    localparam logic [2:0] CODE_T = 3'd3;
    localparam logic [2:0] CODE_N = 3'd4;

    typedef struct packed {
        logic [7:0] nucleotide;
        logic       start_of_sequence;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_BITS-1:0] orf_start;
        logic [OUT_BITS-1:0] orf_end;
        logic [1:0]          reading_frame;
        logic                strand_minus;
    } t_out_beat;

    typedef struct packed {
        logic                clr;
        logic                stop;
        logic [POS_BITS-1:0] pos;
        logic [1:0]          frame;
    } t_stop_evt;

    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            8'h41, 8'h61: code = CODE_A;
            8'h43, 8'h63: code = CODE_C;
            8'h47, 8'h67: code = CODE_G;
            8'h54, 8'h74: code = CODE_T;
            default:      code = CODE_N;
        endcase
        return code;
    endfunction

    // first two bases that fix the amino acid regardless of the third
    function automatic logic fourfold(input logic [1:0] a, input logic [1:0] b);
        logic ff;
        case ({a, b})
            4'b00_01, 4'b01_01, 4'b01_10, 4'b01_11,
            4'b10_01, 4'b10_10, 4'b10_11, 4'b11_01: ff = 1'b1;
            default:                                 ff = 1'b0;
        endcase
        return ff;
    endfunction

    function automatic logic codon_is_stop(input logic [2:0] a, input logic [2:0] b,
                                           input logic [2:0] c);
        logic st;
        if (a[2] || b[2]) begin
            st = 1'b1;
        end else if (c[2]) begin
            st = !fourfold(a[1:0], b[1:0]);
        end else if (a == CODE_T && b == CODE_A && (c == CODE_A || c == CODE_G)) begin
            st = 1'b1;
        end else if (a == CODE_T && b == CODE_G && c == CODE_A) begin
            st = 1'b1;
        end else begin
            st = 1'b0;
        end
        return st;
    endfunction

    function automatic logic [1:0] mod3_inc(input logic [1:0] m);
        logic [1:0] r;
        case (m)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/dna_orf_finder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_orf_finder
// Streaming stop-to-stop open reading frame finder, one base per beat.
//
// Input channel: i_in_valid / o_in_stall / i_in_data, one ASCII base a beat;
//   start_of_sequence clears position, codon window and stop history.
// Output channel: o_out_valid / i_out_stall / o_out_data, one ORF a beat.
// Config channel: i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data;
//   index 0 minus_strand, index 1 sequence_length, others ignored.
//   Write only while the block is idle.
// Throughput: one base per cycle while o_in_stall is low. The front decodes and
//   classifies codons, a two-entry event queue feeds the back, which updates
//   per-frame history and fills the output register.
// Path: the event of a stop codon is queued as its closing base is accepted;
//   o_out_valid is registered from the queue head, later behind older events.
// Stall: a stalled output holds its beat and the back stops popping; the front
//   keeps going until the queue fills, then o_in_stall rises. Only stop and restart
//   beats occupy the queue.
// Reset: clears control state, stop history and both config registers; queue entries and output data are not cleared.
// ----------------------------------------------------------------------------
module dna_orf_finder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dof_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dof_pkg::t_out_beat                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dof_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [dof_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic                              r_minus_strand;
    logic [dof_pkg::CFG_DATA_BITS-1:0] r_seq_len;
    logic                              push, full, pop, empty;
    dof_pkg::t_stop_evt                push_evt, head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minus_strand <= 1'b0;
            r_seq_len      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dof_pkg::REG_MINUS_STRAND:    r_minus_strand <= i_cfg_data[0];
                dof_pkg::REG_SEQUENCE_LENGTH: r_seq_len      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dof_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_queue_full (full),
        .o_push       (push),
        .o_push_evt   (push_evt)
    );

    dof_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_evt (push_evt),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head     (head)
    );

    dof_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_minus_strand (r_minus_strand),
        .i_seq_len      (r_seq_len),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule

[hw/rtl/dof_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_front
// Decodes bases, tracks position and codon window, flags stop codons.
// ----------------------------------------------------------------------------
module dof_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dof_pkg::t_in_beat i_in_data,
    input  logic              i_queue_full,
    output logic              o_push,
    output dof_pkg::t_stop_evt o_push_evt
);

    logic [dof_pkg::POS_BITS-1:0] r_pos, n_pos, pos_eff;
    logic [1:0]                   r_mod3, n_mod3, mod3_eff;
    logic [2:0]                   r_win0, r_win1, win0_eff, win1_eff;
    logic [2:0]                   code;
    logic                         accept, sos, codon_ok, stop;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign sos        = i_in_data.start_of_sequence;

    always_comb begin
        pos_eff  = sos ? '0 : r_pos;
        mod3_eff = sos ? 2'd0 : r_mod3;
        win0_eff = sos ? 3'd0 : r_win0;
        win1_eff = sos ? 3'd0 : r_win1;
        code     = dof_pkg::base_code(i_in_data.nucleotide);
        codon_ok = (pos_eff >= dof_pkg::POS_BITS'(2));
        stop     = codon_ok && dof_pkg::codon_is_stop(win1_eff, win0_eff, code);
        n_pos    = pos_eff + dof_pkg::POS_BITS'(1);
        n_mod3   = (pos_eff == '1) ? 2'd0 : dof_pkg::mod3_inc(mod3_eff);
    end

    assign o_push           = accept && (sos || stop);
    assign o_push_evt.clr   = sos;
    assign o_push_evt.stop  = stop;
    assign o_push_evt.pos   = pos_eff - dof_pkg::POS_BITS'(2);
    assign o_push_evt.frame = dof_pkg::mod3_inc(mod3_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_mod3 <= 2'd0;
            r_win0 <= 3'd0;
            r_win1 <= 3'd0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_mod3 <= n_mod3;
            r_win0 <= code;
            r_win1 <= win0_eff;
        end
    end

endmodule

[hw/rtl/dof_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_queue
// Short FIFO of stop and clear events between front and back.
// ----------------------------------------------------------------------------
module dof_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dof_pkg::t_stop_evt i_push_evt,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output dof_pkg::t_stop_evt o_head
);

    dof_pkg::t_stop_evt                 r_mem [dof_pkg::QUEUE_DEPTH];
    logic [dof_pkg::QUEUE_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [dof_pkg::QUEUE_CNT_BITS-1:0] r_count;
    logic                               do_push, do_pop;

    assign o_full  = (r_count == dof_pkg::QUEUE_CNT_BITS'(dof_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == dof_pkg::QUEUE_PTR_BITS'(dof_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + dof_pkg::QUEUE_PTR_BITS'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == dof_pkg::QUEUE_PTR_BITS'(dof_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + dof_pkg::QUEUE_PTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + dof_pkg::QUEUE_CNT_BITS'(1);
                2'b01:   r_count <= r_count - dof_pkg::QUEUE_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/dof_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dof_back
// Per-frame stop history, ORF gap check, coordinate mapping, output register.
// ----------------------------------------------------------------------------
module dof_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_empty,
    input  dof_pkg::t_stop_evt               i_head,
    output logic                             o_pop,
    input  logic                             i_minus_strand,
    input  logic [dof_pkg::CFG_DATA_BITS-1:0] i_seq_len,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dof_pkg::t_out_beat               o_out_data
);

    localparam int PB = dof_pkg::POS_BITS;

    logic [PB-1:0]      r_last [dof_pkg::NUM_FRAMES];
    logic               r_seen [dof_pkg::NUM_FRAMES];
    logic               r_out_valid;
    dof_pkg::t_out_beat r_out, n_out;

    logic               take, seen_eff, emit;
    logic [PB-1:0]      prev_eff, len_ext, start_pos, end_pos;
    logic [PB:0]        diff;

    assign take = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_pop = take;

    always_comb begin
        seen_eff = i_head.clr ? 1'b0 : r_seen[i_head.frame];
        prev_eff = i_head.clr ? '0 : r_last[i_head.frame];
        diff     = {1'b0, i_head.pos} - {1'b0, prev_eff};
        emit     = i_head.stop && seen_eff && !diff[PB]
                   && (diff[PB-1:0] > PB'(dof_pkg::CODON_LEN));
        len_ext  = PB'(i_seq_len);
        if (i_minus_strand) begin
            start_pos = len_ext - i_head.pos;
            end_pos   = len_ext - prev_eff - PB'(dof_pkg::MINUS_END_GAP);
        end else begin
            start_pos = prev_eff + PB'(dof_pkg::CODON_LEN);
            end_pos   = i_head.pos - PB'(1);
        end
        n_out.orf_start     = dof_pkg::OUT_BITS'(start_pos);
        n_out.orf_end       = dof_pkg::OUT_BITS'(end_pos);
        n_out.reading_frame = i_head.frame;
        n_out.strand_minus  = i_minus_strand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < dof_pkg::NUM_FRAMES; f++) begin
                r_last[f] <= '0;
                r_seen[f] <= 1'b0;
            end
        end else if (take) begin
            for (int f = 0; f < dof_pkg::NUM_FRAMES; f++) begin
                if (i_head.stop && i_head.frame == 2'(f)) begin
                    r_last[f] <= i_head.pos;
                    r_seen[f] <= 1'b1;
                end else if (i_head.clr) begin
                    r_last[f] <= '0;
                    r_seen[f] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dna_orf_finder. A driver streams nucleotide beats
// from a queue filled by the stimulus process, and a tracker mirrors the
// per-frame stop history to predict each ORF beat. A monitor compares every
// output beat with the oldest predicted ORF. The input idles and the output
// stalls at random. Config is changed between phases, strands and lengths included.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [7:0] LOWER_CASE_BIT = 8'h20;
    localparam int         DRAIN_CYCLES   = 12;
    localparam int         PHASE_BEATS    = 260;
    localparam int         NUM_PHASES     = 6;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    dof_pkg::t_in_beat                  i_in_data = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    dof_pkg::t_out_beat                 o_out_data;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [dof_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [dof_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    // mirrored config and stop history
    logic        minus_cfg = 1'b0;
    logic [31:0] seq_len_cfg = '0;
    logic [31:0] next_pos = '0;
    logic [2:0]  code_old = '0;
    logic [2:0]  code_new = '0;
    logic [31:0] frame_stop [dof_pkg::NUM_FRAMES] = '{default: '0};
    bit          frame_has_stop [dof_pkg::NUM_FRAMES] = '{default: 1'b0};

    dof_pkg::t_in_beat  base_stream [$];
    dof_pkg::t_out_beat orf_expected [$];

    int  errors = 0;
    int  in_wait = 0;
    int  out_wait = 0;
    bit  in_burst = 1'b0;
    bit  out_burst = 1'b0;

    dna_orf_finder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [2:0] nucleotide_code(input logic [7:0] ch);
        logic [2:0] code;
        case (ch)
            "A", "a": code = dof_pkg::CODE_A;
            "C", "c": code = dof_pkg::CODE_C;
            "G", "g": code = dof_pkg::CODE_G;
            "T", "t": code = dof_pkg::CODE_T;
            default:  code = dof_pkg::CODE_N;
        endcase
        return code;
    endfunction

    // translation is '*' or 'X'
    function automatic bit codon_stops(input logic [2:0] first, input logic [2:0] second,
                                       input logic [2:0] third);
        bit wobble_free;
        if (first == dof_pkg::CODE_N || second == dof_pkg::CODE_N) begin
            return 1'b1;
        end
        wobble_free = (second == dof_pkg::CODE_C) ||
                      ((first == dof_pkg::CODE_C || first == dof_pkg::CODE_G) &&
                       second != dof_pkg::CODE_A);
        if (third == dof_pkg::CODE_N) begin
            return !wobble_free;
        end
        return (first == dof_pkg::CODE_T && second == dof_pkg::CODE_A &&
                (third == dof_pkg::CODE_A || third == dof_pkg::CODE_G)) ||
               (first == dof_pkg::CODE_T && second == dof_pkg::CODE_G &&
                third == dof_pkg::CODE_A);
    endfunction

    task automatic find_orf(input dof_pkg::t_in_beat beat);
        logic [2:0]         code;
        logic [31:0]        stop_pos;
        logic [31:0]        prev_stop;
        int unsigned        fr;
        dof_pkg::t_out_beat orf;
        if (beat.start_of_sequence) begin
            next_pos = '0;
            code_old = '0;
            code_new = '0;
            frame_stop = '{default: '0};
            frame_has_stop = '{default: 1'b0};
        end
        code = nucleotide_code(beat.nucleotide);
        if (next_pos >= 2) begin
            stop_pos = next_pos - 32'd2;
            fr = stop_pos % 3;
            if (codon_stops(code_old, code_new, code)) begin
                prev_stop = frame_stop[fr];
                if (frame_has_stop[fr] && stop_pos > prev_stop && stop_pos - prev_stop > 3) begin
                    if (minus_cfg) begin
                        orf.orf_start = seq_len_cfg - stop_pos;
                        orf.orf_end   = seq_len_cfg - prev_stop - 32'd4;
                    end else begin
                        orf.orf_start = prev_stop + 32'd3;
                        orf.orf_end   = stop_pos - 32'd1;
                    end
                    orf.reading_frame = fr[1:0];
                    orf.strand_minus  = minus_cfg;
                    orf_expected.push_back(orf);
                end
                frame_stop[fr] = stop_pos;
                frame_has_stop[fr] = 1'b1;
            end
        end
        code_old = code_new;
        code_new = code;
        next_pos = next_pos + 32'd1;
    endtask

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            errors++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                find_orf(i_in_data);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_wait > 0) begin
                    in_wait--;
                    i_in_valid <= 1'b0;
                end else if (base_stream.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= base_stream.pop_front();
                    if ($urandom_range(0, 49) == 0) begin
                        in_burst = !in_burst;
                    end
                    in_wait = in_burst ? 0 : $urandom_range(0, 4);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        dof_pkg::t_out_beat exp_orf;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (orf_expected.size() == 0) begin
                    $error("unexpected ORF beat: start %0d end %0d frame %0d",
                           o_out_data.orf_start, o_out_data.orf_end,
                           o_out_data.reading_frame);
                    errors++;
                end else begin
                    exp_orf = orf_expected.pop_front();
                    check_field("orf_start", exp_orf.orf_start, o_out_data.orf_start);
                    check_field("orf_end", exp_orf.orf_end, o_out_data.orf_end);
                    check_field("reading_frame", 32'(exp_orf.reading_frame),
                                32'(o_out_data.reading_frame));
                    check_field("strand_minus", 32'(exp_orf.strand_minus),
                                32'(o_out_data.strand_minus));
                end
                if ($urandom_range(0, 49) == 0) begin
                    out_burst = !out_burst;
                end
                out_wait = out_burst ? 0 : $urandom_range(0, 4);
            end
            if (out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [dof_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [dof_pkg::CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == dof_pkg::REG_MINUS_STRAND) begin
            minus_cfg = value[0];
        end else if (index == dof_pkg::REG_SEQUENCE_LENGTH) begin
            seq_len_cfg = value;
        end
    endtask

    task automatic drain();
        while (base_stream.size() != 0 || i_in_valid || orf_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void push_base(input logic [7:0] nucleotide, input bit restart);
        dof_pkg::t_in_beat beat;
        beat.nucleotide = nucleotide;
        beat.start_of_sequence = restart;
        base_stream.push_back(beat);
    endfunction

    function automatic logic [7:0] random_case(input logic [7:0] ch);
        return $urandom_range(0, 1) ? (ch | LOWER_CASE_BIT) : ch;
    endfunction

    function automatic void fill_random(input int count);
        string acgt;
        string stops;
        int    pick;
        int    n;
        acgt  = "ACGT";
        stops = "TAATAGTGA";
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 7) == 0) begin
                pick = 3 * $urandom_range(0, 2);
                for (int k = 0; k < 3; k++) begin
                    push_base(random_case(stops[pick + k]), n == 0);
                    n++;
                end
            end else begin
                case ($urandom_range(0, 19))
                    0: push_base(8'($urandom_range(0, 255)), n == 0);
                    1: push_base(random_case("N"), n == 0);
                    default: push_base(random_case(acgt[$urandom_range(0, 3)]),
                                       n == 0 || $urandom_range(0, 299) == 0);
                endcase
                n++;
            end
        end
    endfunction

    initial begin
        string       directed;
        logic [31:0] lengths [NUM_PHASES];
        logic        strands [NUM_PHASES];
        lengths = '{32'($urandom), 32'd0, 32'hFFFF_FFFF, 32'd50, 32'd300, 32'($urandom)};
        strands = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(dof_pkg::CFG_INDEX_BITS'($urandom_range(2 ** dof_pkg::CFG_INDEX_BITS - 1,
                                                           dof_pkg::REG_SEQUENCE_LENGTH + 1)),
                  dof_pkg::CFG_DATA_BITS'($urandom));

        // first stop, gapped stop, adjacent stop, N codons, odd bytes, restart
        directed = "ATAAcgtTagTGANGCCn";
        for (int k = 0; k < directed.len(); k++) begin
            push_base(directed[k], k == 0);
        end
        push_base(8'h00, 1'b0);
        push_base(8'hFF, 1'b0);
        push_base("g", 1'b1);
        push_base("T", 1'b0);
        push_base("A", 1'b0);
        push_base("G", 1'b0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(dof_pkg::REG_MINUS_STRAND, dof_pkg::CFG_DATA_BITS'(strands[p]));
            write_reg(dof_pkg::REG_SEQUENCE_LENGTH, lengths[p]);
            fill_random(PHASE_BEATS);
            drain();
        end

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dof_pkg.sv
hw/rtl/dof_front.sv
hw/rtl/dof_queue.sv
hw/rtl/dof_back.sv
hw/rtl/dna_orf_finder.sv
bench/tb_top.sv
